// ===== design/glu_pkg.sv =====
// glu_pkg: shared types and state codes for gcd_lcm_unit.
// No dependencies.
package glu_pkg;

    typedef struct packed {
        logic [31:0] a_value;
        logic [31:0] b_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] gcd_value;
        logic [63:0] lcm_value;
        logic        zero_operand;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_LCM_DIV,
        ST_LCM_MUL,
        ST_DONE
    } t_state;

    // control to the divider chain
    typedef struct packed {
        logic start;
    } t_div_ctrl;

endpackage

// ===== design/glu_div_cell.sv =====
// glu_div_cell: one restoring-division step: shift one dividend bit into the
// partial remainder, try a subtract, pass the result to the next cell.
// Depends on nothing.
module glu_div_cell #(
    parameter int W = 32
) (
    input  logic [W-1:0] i_rem,
    input  logic [W-1:0] i_quo,
    input  logic [W-1:0] i_div,
    output logic [W-1:0] o_rem,
    output logic [W-1:0] o_quo
);
    logic [W:0] shifted;
    logic [W:0] diff;

    always_comb begin
        shifted = {i_rem, i_quo[W-1]};
        diff    = shifted - {1'b0, i_div};
        if (!diff[W]) begin
            o_rem = diff[W-1:0];
            o_quo = {i_quo[W-2:0], 1'b1};
        end else begin
            o_rem = shifted[W-1:0];
            o_quo = {i_quo[W-2:0], 1'b0};
        end
    end
endmodule

// ===== design/glu_divider.sv =====
// glu_divider: iterative unsigned divider built from a row of division cells;
// each cycle the chain resolves CELLS quotient bits. Depends on glu_pkg, glu_div_cell.
module glu_divider #(
    parameter int W     = 32,
    parameter int CELLS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  glu_pkg::t_div_ctrl   i_ctrl,
    input  logic [W-1:0]         i_dividend,
    input  logic [W-1:0]         i_divisor,
    output logic                 o_done,
    output logic [W-1:0]         o_quotient,
    output logic [W-1:0]         o_remainder
);
    localparam int STEPS = (W + CELLS - 1) / CELLS;
    localparam int CW    = $clog2(STEPS + 1);
    // datapath runs on a whole number of steps; operands are zero-extended
    localparam int WP    = STEPS * CELLS;

    logic [WP-1:0] r_rem, n_rem;
    logic [WP-1:0] r_quo, n_quo;
    logic [WP-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [WP-1:0] rem_c [CELLS+1];
    logic [WP-1:0] quo_c [CELLS+1];

    assign rem_c[0] = r_rem;
    assign quo_c[0] = r_quo;

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        glu_div_cell #(.W(WP)) u_cell (
            .i_rem(rem_c[k]), .i_quo(quo_c[k]), .i_div(r_div),
            .o_rem(rem_c[k+1]), .o_quo(quo_c[k+1])
        );
    end

    always_comb begin
        n_rem = rem_c[CELLS];
        n_quo = quo_c[CELLS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctrl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_rem <= '0;
            r_quo <= WP'(i_dividend);
            r_div <= WP'(i_divisor);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done      = r_busy && (r_cnt == CW'(1));
    assign o_quotient  = n_quo[W-1:0];
    assign o_remainder = n_rem[W-1:0];
endmodule

// ===== design/gcd_lcm_unit.sv =====
// gcd_lcm_unit: GCD by Euclid's remainder loop, LCM = (a / gcd) * b.
// A zero operand skips the divider and goes straight to the result. One item
// at a time; the result sits in an output register, so the next item is taken
// meanwhile. Reset (synchronous, active low) clears control state only.
module gcd_lcm_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  glu_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output glu_pkg::t_out_item o_data
);
    localparam int W = OPERAND_WIDTH;

    glu_pkg::t_state r_state, n_state;
    logic [W-1:0] r_a, r_b, r_big, r_small, r_gcd, r_quo;
    logic [63:0]  r_lcm;
    logic         r_oval;
    glu_pkg::t_out_item r_out;

    glu_pkg::t_div_ctrl div_ctrl;
    logic [W-1:0] div_dnd, div_dsr, div_q, div_r;
    logic         div_done;

    logic [W-1:0] in_a, in_b;
    assign in_a = i_data.a_value[W-1:0];
    assign in_b = i_data.b_value[W-1:0];

    glu_divider #(.W(W), .CELLS(4)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(div_ctrl),
        .i_dividend(div_dnd), .i_divisor(div_dsr),
        .o_done(div_done), .o_quotient(div_q), .o_remainder(div_r)
    );

    // an item is taken only in IDLE; DONE moves on only if the output slot is free
    // or emptying this cycle
    logic out_free;
    assign out_free = !r_oval || i_ready;
    assign o_ready  = (r_state == glu_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            glu_pkg::ST_IDLE:     if (i_valid) n_state = glu_pkg::ST_DIV_LOAD;
            glu_pkg::ST_DIV_LOAD: begin
                if (r_a == '0 || r_b == '0) n_state = glu_pkg::ST_DONE;
                else                        n_state = glu_pkg::ST_DIV_RUN;
            end
            glu_pkg::ST_DIV_RUN:  begin
                if (div_done && div_r == '0) n_state = glu_pkg::ST_LCM_DIV;
                else if (div_done)           n_state = glu_pkg::ST_DIV_RUN;
            end
            glu_pkg::ST_LCM_DIV:  if (div_done) n_state = glu_pkg::ST_LCM_MUL;
            glu_pkg::ST_LCM_MUL:  n_state = glu_pkg::ST_DONE;
            glu_pkg::ST_DONE:     if (out_free) n_state = glu_pkg::ST_IDLE;
            default:              n_state = glu_pkg::ST_IDLE;
        endcase
    end

    // divider operands and start pulses
    always_comb begin
        div_ctrl.start = 1'b0;
        div_dnd = r_big;
        div_dsr = r_small;
        case (r_state)
            glu_pkg::ST_DIV_LOAD: begin
                // first divide takes the ordered pair straight from the operands
                div_ctrl.start = (r_a != '0) && (r_b != '0);
                div_dnd = (r_a > r_b) ? r_a : r_b;
                div_dsr = (r_a > r_b) ? r_b : r_a;
            end
            glu_pkg::ST_DIV_RUN: begin
                div_dnd = r_small;
                div_dsr = div_r;
                if (div_done && div_r == '0) begin
                    div_dnd = r_a;
                    div_dsr = r_small;
                end
                div_ctrl.start = div_done;
            end
            default: div_ctrl.start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= glu_pkg::ST_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == glu_pkg::ST_DONE && out_free) r_oval <= 1'b1;
            else if (i_ready)                            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            glu_pkg::ST_IDLE: begin
                r_a <= in_a;
                r_b <= in_b;
            end
            glu_pkg::ST_DIV_LOAD: begin
                r_big   <= (r_a > r_b) ? r_a : r_b;
                r_small <= (r_a > r_b) ? r_b : r_a;
                r_gcd   <= (r_a == '0) ? r_b : r_a;
                r_lcm   <= '0;
            end
            glu_pkg::ST_DIV_RUN: if (div_done) begin
                r_big   <= r_small;
                r_small <= div_r;
                if (div_r == '0) r_gcd <= r_small;
            end
            glu_pkg::ST_LCM_DIV: if (div_done) r_quo <= div_q;
            glu_pkg::ST_LCM_MUL: r_lcm <= 64'(r_quo) * 64'(r_b);
            glu_pkg::ST_DONE: if (out_free) begin
                r_out.gcd_value    <= 32'(r_gcd);
                r_out.lcm_value    <= r_lcm;
                r_out.zero_operand <= (r_a == '0) || (r_b == '0);
            end
            default: ;
        endcase
    end

    assign o_valid = r_oval;
    assign o_data  = r_out;

    // a result never disappears while it waits
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result dropped or changed while stalled");
    // divider finishes only while a divide is under way
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == glu_pkg::ST_DIV_RUN || r_state == glu_pkg::ST_LCM_DIV))
        else $error("divider done outside a divide");
    // gcd is never zero when both operands are nonzero
    a_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == glu_pkg::ST_LCM_MUL |-> r_gcd != '0)
        else $error("zero gcd for nonzero operands");
endmodule
